>>> rtl/sba_pkg.sv
// ----------------------------------------------------------------------------
// sba_pkg
// Shared types and constants of the shared buffer admission core: action
// codes, register indexes, register reset values, the register bundle and
// the controller command group.
// ----------------------------------------------------------------------------
package sba_pkg;

    localparam int ACTION_W = 2;
    localparam int QSEL_W   = 3;
    localparam int BYTES_W  = 14;
    localparam int POOL_W   = 24;
    localparam int ALPHA_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_ENQUEUE  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RELEASE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SCHEDULE = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ADMISSION_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_QUEUES     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHARED_BYTES   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVE_BYTES  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_TABLE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCHEDULER_MODE = 3'd5;

    // Register reset values
    localparam logic              RST_ADMISSION_MODE = 1'b0;
    localparam logic [3:0]        RST_NUM_QUEUES     = 4'd5;
    localparam logic [POOL_W-1:0] RST_SHARED_BYTES   = 24'd1048576;
    localparam logic [POOL_W-1:0] RST_RESERVE_BYTES  = 24'd0;
    localparam logic [63:0]       RST_ALPHA_TABLE    = 64'h1010_1010_1010_1010;
    localparam logic              RST_SCHEDULER_MODE = 1'b0;

    typedef struct packed {
        logic              admission_mode;
        logic [3:0]        num_queues;
        logic [POOL_W-1:0] shared_buffer_bytes;
        logic [POOL_W-1:0] static_reserve_bytes;
        logic [63:0]       alpha_table;
        logic              scheduler_mode;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic read;
        logic mul;
        logic exec;
        logic load_out;
    } cmd_t;

endpackage

>>> rtl/sba_cfg.sv
// ----------------------------------------------------------------------------
// sba_cfg
// Configuration register file. Takes one register write per transfer and
// presents the full register set to the datapath.
// ----------------------------------------------------------------------------
module sba_cfg
    import sba_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ADMISSION_MODE: cfg_next.admission_mode       = cfg_data[0];
                CFG_NUM_QUEUES:     cfg_next.num_queues           = cfg_data[3:0];
                CFG_SHARED_BYTES:   cfg_next.shared_buffer_bytes  = cfg_data[POOL_W-1:0];
                CFG_RESERVE_BYTES:  cfg_next.static_reserve_bytes = cfg_data[POOL_W-1:0];
                CFG_ALPHA_TABLE:    cfg_next.alpha_table          = cfg_data;
                CFG_SCHEDULER_MODE: cfg_next.scheduler_mode       = cfg_data[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.admission_mode       <= RST_ADMISSION_MODE;
            cfg_reg.num_queues           <= RST_NUM_QUEUES;
            cfg_reg.shared_buffer_bytes  <= RST_SHARED_BYTES;
            cfg_reg.static_reserve_bytes <= RST_RESERVE_BYTES;
            cfg_reg.alpha_table          <= RST_ALPHA_TABLE;
            cfg_reg.scheduler_mode       <= RST_SCHEDULER_MODE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> rtl/sba_ctrl.sv
// ----------------------------------------------------------------------------
// sba_ctrl
// Sequencer of the admission core. Steps each item through read, multiply,
// update and output load, and owns the output valid flag.
// ----------------------------------------------------------------------------
module sba_ctrl
    import sba_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_EXEC = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       fin_go;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Load the output register only once the previous result has gone
    assign fin_go = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

    always_comb
    begin
        cmd.capture  = in_valid && (state_reg == S_IDLE);
        cmd.read     = (state_reg == S_READ);
        cmd.mul      = (state_reg == S_MUL);
        cmd.exec     = (state_reg == S_EXEC);
        cmd.load_out = fin_go;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_valid) state_next = S_READ;
            S_READ: state_next = S_MUL;
            S_MUL:  state_next = S_EXEC;
            S_EXEC: state_next = S_FIN;
            S_FIN:  if (fin_go) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fin_go)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.read, cmd.mul, cmd.exec, cmd.load_out}))
        else $error("more than one datapath command active");

    a_capture_to_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == S_READ) && !in_ready)
        else $error("accepted item did not start the read step");

    a_exec_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> (state_reg == S_FIN))
        else $error("update step not followed by output load step");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid && in_ready)
        else $error("loaded result not presented");
`endif

endmodule

>>> rtl/sba_dp.sv
// ----------------------------------------------------------------------------
// sba_dp
// Datapath of the admission core: queue and pool counters, the alpha times
// free-bytes threshold multiplier, the queue picker and the output register.
// ----------------------------------------------------------------------------
module sba_dp
    import sba_pkg::*;
#(
    parameter int MAX_QUEUES = 8,
    parameter int COUNT_BITS = 24
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    input  cfg_t                cfg,
    input  logic [ACTION_W-1:0] action,
    input  logic [QSEL_W-1:0]   queue_index,
    input  logic [BYTES_W-1:0]  packet_bytes,
    output logic                accepted,
    output logic                reserve_used,
    output logic [QSEL_W-1:0]   queue_selected,
    output logic                selected_valid,
    output logic [POOL_W-1:0]   shared_remaining
);

    localparam int QW     = (MAX_QUEUES > 2) ? $clog2(MAX_QUEUES) : 1;
    localparam int TOPQ   = (MAX_QUEUES < 8) ? MAX_QUEUES : 8;
    localparam int CW     = (COUNT_BITS > POOL_W) ? COUNT_BITS : POOL_W;
    localparam int SW     = COUNT_BITS + 1;
    localparam int PROD_W = ALPHA_W + POOL_W;
    localparam int THR_W  = PROD_W - 4;
    localparam int MW     = (SW > THR_W) ? SW : THR_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    function automatic logic [COUNT_BITS-1:0] cnt_sat(input logic [SW-1:0] s);
        return s[SW-1] ? CNT_MAX : s[COUNT_BITS-1:0];
    endfunction

    function automatic logic [COUNT_BITS-1:0] cnt_sub(
        input logic [COUNT_BITS-1:0] a,
        input logic [BYTES_W-1:0]    b
    );
        logic [COUNT_BITS-1:0] bx;
        bx = COUNT_BITS'(b);
        return (a > bx) ? (a - bx) : '0;
    endfunction

    function automatic logic [POOL_W-1:0] pool_free(
        input logic [POOL_W-1:0]     total,
        input logic [COUNT_BITS-1:0] used
    );
        logic [CW-1:0] t;
        logic [CW-1:0] u;
        logic [CW-1:0] d;
        t = CW'(total);
        u = CW'(used);
        d = t - u;
        return (t > u) ? POOL_W'(d) : '0;
    endfunction

    // State counters
    logic [COUNT_BITS-1:0] qbytes_reg [MAX_QUEUES];
    logic [MAX_QUEUES-1:0] ne_reg;
    logic [COUNT_BITS-1:0] port_reg;
    logic [COUNT_BITS-1:0] port_next;
    logic [COUNT_BITS-1:0] used_reg;
    logic [COUNT_BITS-1:0] used_next;
    logic [QSEL_W-1:0]     rr_reg;
    logic [QSEL_W-1:0]     rr_next;

    // Captured item
    logic [ACTION_W-1:0] action_reg;
    logic [QSEL_W-1:0]   q_reg;
    logic [BYTES_W-1:0]  bytes_reg;
    logic [QW-1:0]       q_idx;

    // Read step
    logic [COUNT_BITS-1:0] qb_reg;
    logic [POOL_W-1:0]     free_reg;
    logic                  fit_reg;
    logic [SW-1:0]         qsum_reg;
    logic [SW-1:0]         psum_reg;
    logic [SW-1:0]         usum_reg;
    logic [ALPHA_W-1:0]    alpha_reg;
    logic [QSEL_W-1:0]     pick_sel_reg;
    logic                  pick_valid_reg;
    logic [QSEL_W-1:0]     rr_new_reg;

    // Multiply step
    logic [PROD_W-1:0] prod_reg;

    // Update step results
    logic              r_acc_reg;
    logic              r_res_reg;
    logic [QSEL_W-1:0] r_sel_reg;
    logic              r_valid_reg;
    logic              r_acc_next;
    logic              r_res_next;
    logic [QSEL_W-1:0] r_sel_next;
    logic              r_valid_next;

    // Output register
    logic              accepted_reg;
    logic              reserve_used_reg;
    logic [QSEL_W-1:0] queue_selected_reg;
    logic              selected_valid_reg;
    logic [POOL_W-1:0] shared_remaining_reg;

    logic [3:0]            nq;
    logic [QSEL_W-1:0]     q_clamped;
    logic [SW-1:0]         psum;
    logic [POOL_W-1:0]     free_now;
    logic [7:0]            ne8;
    logic [QSEL_W-1:0]     p0;
    logic                  rr_found;
    logic [QSEL_W-1:0]     rr_sel;
    logic [QSEL_W-1:0]     rr_after;
    logic                  sp_found;
    logic [QSEL_W-1:0]     sp_sel;
    logic [3:0]            rr_pos;
    logic [THR_W-1:0]      thr;
    logic                  shared_ok;
    logic                  qwr_en;
    logic [COUNT_BITS-1:0] qwr_data;

    // Queue count in use, bounded to the implemented queues
    always_comb
    begin
        if (cfg.num_queues < 4'd2)
            nq = 4'd2;
        else if (cfg.num_queues > 4'(TOPQ))
            nq = 4'(TOPQ);
        else
            nq = cfg.num_queues;
    end

    assign q_clamped = ({1'b0, queue_index} >= nq) ? QSEL_W'(nq - 4'd1) : queue_index;
    assign q_idx     = QW'(q_reg);
    assign psum      = SW'(port_reg) + SW'(bytes_reg);
    assign free_now  = pool_free(cfg.shared_buffer_bytes, used_reg);

    // Non-empty flags widened to the eight selectable queues
    for (genvar g = 0; g < 8; g++)
    begin : g_ne8
        if (g < MAX_QUEUES)
        begin : g_on
            assign ne8[g] = ne_reg[g];
        end
        else
        begin : g_off
            assign ne8[g] = 1'b0;
        end
    end

    assign p0 = ({1'b0, rr_reg} < nq) ? rr_reg : '0;

    // Round robin and strict priority pick over the non-empty flags
    always_comb
    begin
        rr_found = 1'b0;
        rr_sel   = '0;
        sp_found = 1'b0;
        sp_sel   = '0;
        rr_pos   = '0;
        for (int i = 0; i < 8; i++)
        begin
            rr_pos = {1'b0, p0} + 4'(i);
            if (rr_pos >= nq)
                rr_pos = rr_pos - nq;
            if ((4'(i) < nq) && ne8[rr_pos[2:0]] && !rr_found)
            begin
                rr_found = 1'b1;
                rr_sel   = rr_pos[2:0];
            end
            if ((4'(i) < nq) && ne8[i] && !sp_found)
            begin
                sp_found = 1'b1;
                sp_sel   = QSEL_W'(i);
            end
        end
        if (rr_found)
            rr_after = ({1'b0, rr_sel} + 4'd1 >= nq) ? '0 : rr_sel + 3'd1;
        else
            rr_after = p0;
    end

    // Update step
    assign thr = THR_W'(prod_reg >> 4);

    always_comb
    begin
        shared_ok = (free_reg >= POOL_W'(bytes_reg));
        if (!cfg.admission_mode && (MW'(qsum_reg) > MW'(thr)))
            shared_ok = 1'b0;

        port_next    = port_reg;
        used_next    = used_reg;
        rr_next      = rr_reg;
        qwr_en       = 1'b0;
        qwr_data     = qb_reg;
        r_acc_next   = 1'b0;
        r_res_next   = 1'b0;
        r_sel_next   = '0;
        r_valid_next = 1'b0;

        case (action_reg)
            ACT_ENQUEUE:
            begin
                r_sel_next = q_reg;
                if (fit_reg)
                begin
                    r_acc_next = 1'b1;
                    r_res_next = 1'b1;
                end
                else if (shared_ok)
                begin
                    r_acc_next = 1'b1;
                    used_next  = cnt_sat(usum_reg);
                end
                if (r_acc_next)
                begin
                    qwr_en    = 1'b1;
                    qwr_data  = cnt_sat(qsum_reg);
                    port_next = cnt_sat(psum_reg);
                end
            end
            ACT_RELEASE:
            begin
                r_sel_next = q_reg;
                // Shared bytes come back only when the port was past its reserve
                if (CW'(port_reg) > CW'(cfg.static_reserve_bytes))
                    used_next = cnt_sub(used_reg, bytes_reg);
                qwr_en    = 1'b1;
                qwr_data  = cnt_sub(qb_reg, bytes_reg);
                port_next = cnt_sub(port_reg, bytes_reg);
            end
            ACT_SCHEDULE:
            begin
                r_sel_next   = pick_sel_reg;
                r_valid_next = pick_valid_reg;
                if (!cfg.scheduler_mode)
                    rr_next = rr_new_reg;
            end
            default:
            begin
                r_sel_next = '0;
            end
        endcase
    end

    // Counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_QUEUES; i++)
                qbytes_reg[i] <= '0;
            ne_reg   <= '0;
            port_reg <= '0;
            used_reg <= '0;
            rr_reg   <= '0;
        end
        else if (cmd.exec)
        begin
            if (qwr_en)
            begin
                qbytes_reg[q_idx] <= qwr_data;
                ne_reg[q_idx]     <= (qwr_data != '0);
            end
            port_reg <= port_next;
            used_reg <= used_next;
            rr_reg   <= rr_next;
        end
    end

    // Item pipeline registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= action;
            q_reg      <= q_clamped;
            bytes_reg  <= packet_bytes;
        end
        if (cmd.read)
        begin
            qb_reg         <= qbytes_reg[q_idx];
            free_reg       <= free_now;
            fit_reg        <= (MW'(psum) <= MW'(cfg.static_reserve_bytes));
            qsum_reg       <= SW'(qbytes_reg[q_idx]) + SW'(bytes_reg);
            psum_reg       <= psum;
            usum_reg       <= SW'(used_reg) + SW'(bytes_reg);
            alpha_reg      <= ALPHA_W'(cfg.alpha_table >> {q_reg, 3'b000});
            pick_sel_reg   <= cfg.scheduler_mode ? sp_sel : rr_sel;
            pick_valid_reg <= cfg.scheduler_mode ? sp_found : rr_found;
            rr_new_reg     <= rr_after;
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(alpha_reg) * PROD_W'(free_reg);
        end
        if (cmd.exec)
        begin
            r_acc_reg   <= r_acc_next;
            r_res_reg   <= r_res_next;
            r_sel_reg   <= r_sel_next;
            r_valid_reg <= r_valid_next;
        end
        if (cmd.load_out)
        begin
            accepted_reg         <= r_acc_reg;
            reserve_used_reg     <= r_res_reg;
            queue_selected_reg   <= r_sel_reg;
            selected_valid_reg   <= r_valid_reg;
            shared_remaining_reg <= free_now;
        end
    end

    assign accepted         = accepted_reg;
    assign reserve_used     = reserve_used_reg;
    assign queue_selected   = queue_selected_reg;
    assign selected_valid   = selected_valid_reg;
    assign shared_remaining = shared_remaining_reg;

endmodule

>>> rtl/shared_buffer_admission_core.sv
// ----------------------------------------------------------------------------
// shared_buffer_admission_core: queue admission against a shared buffer pool
// Each item is captured, then stepped through the read, multiply, update and
// output load steps; the output load waits until the previous result is taken.
// One item is in flight at a time; the next item is taken while a result waits.
// Reset: counters zero, registers at defaults, no clearing pass.
// ----------------------------------------------------------------------------
module shared_buffer_admission_core
    import sba_pkg::*;
#(
    parameter int MAX_QUEUES = 8,
    parameter int COUNT_BITS = 24
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [ACTION_W-1:0]   action,
    input  logic [QSEL_W-1:0]     queue_index,
    input  logic [BYTES_W-1:0]    packet_bytes,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  accepted,
    output logic                  reserve_used,
    output logic [QSEL_W-1:0]     queue_selected,
    output logic                  selected_valid,
    output logic [POOL_W-1:0]     shared_remaining
);

    cfg_t cfg;
    cmd_t cmd;

    sba_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    sba_dp #(
        .MAX_QUEUES (MAX_QUEUES),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .cfg              (cfg),
        .action           (action),
        .queue_index      (queue_index),
        .packet_bytes     (packet_bytes),
        .accepted         (accepted),
        .reserve_used     (reserve_used),
        .queue_selected   (queue_selected),
        .selected_valid   (selected_valid),
        .shared_remaining (shared_remaining)
    );

endmodule
